FILE: rtl/htlp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the linear-probe hash table
// no dependencies

package htlp_pkg;

  localparam int TABLE_SLOTS  = 32;
  localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SLOT_FIELD_W = 5;
  localparam int KEY_W        = 15;
  localparam int VAL_W        = 32;
  localparam int SQ_W         = 2 * KEY_W;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] id;
    logic signed [VAL_W-1:0] phone;
    logic [SLOT_W-1:0]       home;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] id;
    logic signed [VAL_W-1:0] phone;
  } entry_t;

  // low bits of a slot index as shown on the result port
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

FILE: rtl/htlp_front.sv
`timescale 1ns / 1ps
// front stage: takes request transfers, squares the key and forms the home slot
// depends on htlp_pkg

module htlp_front import htlp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [KEY_W-1:0]        key,
  input  logic signed [VAL_W-1:0] id,
  input  logic signed [VAL_W-1:0] phone,
  input  logic                    q_full,
  output logic                    push,
  output item_t                   push_item
);

  logic              f_vld;
  cmd_t              f_cmd;
  logic [KEY_W-1:0]  f_key;
  logic [VAL_W-1:0]  f_id;
  logic [VAL_W-1:0]  f_phone;
  logic [SQ_W-1:0]   f_sq;
  logic              accept;

  assign in_stall = f_vld && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_vld && !q_full;

  always_comb begin
    push_item.cmd   = f_cmd;
    push_item.key   = f_key;
    push_item.id    = f_id;
    push_item.phone = f_phone;
    push_item.home  = SLOT_W'(f_sq % TABLE_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
    if (accept) begin
      f_cmd   <= cmd_t'(cmd);
      f_key   <= key;
      f_id    <= id;
      f_phone <= phone;
      f_sq    <= SQ_W'(key * key);
    end
  end

endmodule

FILE: rtl/htlp_queue.sv
`timescale 1ns / 1ps
// short request queue between the front stage and the table engine
// depends on htlp_pkg

module htlp_queue import htlp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_vld,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_vld = (count != '0);
  assign head  = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      buf_q[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/htlp_back.sv
`timescale 1ns / 1ps
// table engine: valid bits, entry memory, insert probe, lookup scan, result register
// depends on htlp_pkg

module htlp_back import htlp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_vld,
  input  item_t                   head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [SLOT_FIELD_W-1:0] slot
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_LK,
    S_DONE
  } state_t;

  state_t                  state;
  item_t                   cur;
  logic [SLOT_W-1:0]       pos;
  logic [SLOT_W-1:0]       cnt;
  logic [SLOT_W-1:0]       issue_idx;
  logic                    issue_on;
  logic [SLOT_W-1:0]       cmp_idx;
  logic                    cmp_vld;
  logic [TABLE_SLOTS-1:0]  slot_valid;
  status_t                 res_status;
  logic [SLOT_FIELD_W-1:0] res_slot;
  status_t                 out_status;
  logic [SLOT_FIELD_W-1:0] out_slot;

  entry_t                  mem [TABLE_SLOTS];
  entry_t                  rd_data;
  logic                    mem_we;
  logic                    hit;

  assign pop    = (state == S_IDLE) && q_vld;
  assign mem_we = (state == S_INS) && !slot_valid[pos];
  assign hit    = cmp_vld && slot_valid[cmp_idx] && (rd_data.key == cur.key)
                  && (rd_data.id == cur.id) && (rd_data.phone == cur.phone);
  assign status = out_status;
  assign slot   = out_slot;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= '{key: cur.key, id: cur.id, phone: cur.phone};
    end
    rd_data <= mem[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      issue_on   <= 1'b0;
      cmp_vld    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_vld) begin
            cur       <= head;
            pos       <= head.home;
            cnt       <= '0;
            issue_idx <= '0;
            issue_on  <= 1'b1;
            cmp_vld   <= 1'b0;
            state     <= (head.cmd == CMD_INSERT) ? S_INS : S_LK;
          end
        end
        S_INS: begin
          if (!slot_valid[pos]) begin
            slot_valid[pos] <= 1'b1;
            res_status      <= ST_INSERTED;
            res_slot        <= slot_field(pos);
            state           <= S_DONE;
          end else if (cnt == SLOT_LAST) begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            pos <= (pos == SLOT_LAST) ? '0 : pos + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        S_LK: begin
          cmp_vld <= issue_on;
          cmp_idx <= issue_idx;
          if (issue_on) begin
            if (issue_idx == SLOT_LAST) begin
              issue_on <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (hit) begin
            res_status <= ST_FOUND;
            res_slot   <= slot_field(cmp_idx);
            state      <= S_DONE;
          end else if (cmp_vld && cmp_idx == SLOT_LAST) begin
            res_status <= ST_MISSING;
            res_slot   <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_slot   <= res_slot;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hash_table_linear_probe.sv
`timescale 1ns / 1ps
// Linear-probe hash table of key/id/phone entries, 32 slots with valid bits.
// Request channel: in_valid/in_stall with cmd, key, id, phone; a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with status and slot, one result per
// request, in request order.
// An insert hashes key*key mod the slot count and probes forward one slot
// per cycle to the first free slot. A lookup scans slot 0 upward through
// the entry memory, one read per cycle with registered read data.
// A request passes the front-stage register and the queue to the engine;
// the engine passes through a done state that loads the result register
// and returns to idle before it takes the next request, so requests run
// one at a time.
// A two-entry queue sits between the front stage and the engine, so up to
// four requests can be taken while a result waits on out_stall.
// Synchronous reset clears all valid bits, the queue and the result
// register; no clearing pass is needed.
// depends on htlp_pkg, htlp_front, htlp_queue, htlp_back

module hash_table_linear_probe import htlp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [KEY_W-1:0]        key,
  input  logic signed [VAL_W-1:0] id,
  input  logic signed [VAL_W-1:0] phone,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [SLOT_FIELD_W-1:0] slot
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_vld;
  item_t head;

  htlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .key       (key),
    .id        (id),
    .phone     (phone),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  htlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_vld     (q_vld),
    .head      (head)
  );

  htlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_vld     (q_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot      (slot)
  );

endmodule

FILE: rtl/htlp_checker.sv
`timescale 1ns / 1ps
// port-level checks for the hash table, attached by bind
// depends on htlp_pkg and hash_table_linear_probe

module htlp_checker import htlp_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              status,
  input logic [SLOT_FIELD_W-1:0] slot
);

  // no slot reported for a dropped insert or a lookup miss
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_MISSING) |-> slot == '0)
    else $error("slot not zero on full or miss result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .slot      (slot)
);

FILE: test/tb_hash_table_linear_probe.sv
`timescale 1ns / 1ps
// testbench for hash_table_linear_probe: directed and random insert/lookup transfers,
// bursty sender and patterned result stall, checked against a table mirror class
// depends on htlp_pkg and hash_table_linear_probe

module tb_hash_table_linear_probe;
  import htlp_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } answer_t;

  class hash_table_mirror;
    bit               used   [TABLE_SLOTS];
    logic [KEY_W-1:0] keys   [TABLE_SLOTS];
    logic [VAL_W-1:0] ids    [TABLE_SLOTS];
    logic [VAL_W-1:0] phones [TABLE_SLOTS];
    answer_t          answers_due [$];
    int               errors;

    function int pending();
      return answers_due.size();
    endfunction

    function int filled();
      int n;
      n = 0;
      foreach (used[s]) n += used[s];
      return n;
    endfunction

    function void pick_entry(output logic [KEY_W-1:0] k, output logic [VAL_W-1:0] i,
                             output logic [VAL_W-1:0] p);
      int s;
      do s = $urandom_range(TABLE_SLOTS - 1); while (!used[s]);
      k = keys[s];
      i = ids[s];
      p = phones[s];
    endfunction

    function void note_request(cmd_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] i,
                               logic [VAL_W-1:0] p);
      answer_t         a;
      logic [SQ_W-1:0] sq;
      int              pos;
      a.slot = '0;
      if (c == CMD_INSERT) begin
        a.status = ST_FULL;
        sq = SQ_W'(k) * SQ_W'(k);
        pos = int'(sq % TABLE_SLOTS);
        for (int n = 0; n < TABLE_SLOTS; n++) begin
          if (!used[pos]) begin
            used[pos] = 1'b1;
            keys[pos] = k;
            ids[pos] = i;
            phones[pos] = p;
            a.status = ST_INSERTED;
            a.slot = SLOT_FIELD_W'(pos);
            break;
          end
          pos = (pos + 1) % TABLE_SLOTS;
        end
      end else begin
        a.status = ST_MISSING;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
          if (used[n] && keys[n] == k && ids[n] == i && phones[n] == p) begin
            a.status = ST_FOUND;
            a.slot = SLOT_FIELD_W'(n);
            break;
          end
        end
      end
      answers_due.push_back(a);
    endfunction

    function void check_result(logic [1:0] st, logic [SLOT_FIELD_W-1:0] sl);
      answer_t a;
      if (answers_due.size() == 0) begin
        $error("unexpected result transfer: status %0d slot %0d", st, sl);
        errors++;
        return;
      end
      a = answers_due.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, actual %0d", a.status, st);
        errors++;
      end
      if (sl !== a.slot) begin
        $error("slot: expected %0d, actual %0d", a.slot, sl);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    cmd = CMD_INSERT;
  logic [KEY_W-1:0]        key = '0;
  logic signed [VAL_W-1:0] id = '0;
  logic signed [VAL_W-1:0] phone = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              status;
  logic [SLOT_FIELD_W-1:0] slot;

  hash_table_mirror mirror = new;

  hash_table_linear_probe uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .key      (key),
    .id       (id),
    .phone    (phone),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .slot     (slot)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) mirror.check_result(status, slot);
  end

  // result stall pattern: free-running, light, heavy and near-blocked stretches
  initial begin : stall_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(1) == 0);
          default: out_stall <= ($urandom_range(15) != 0);
        endcase
      end
    end
  end

  task automatic send_request(input cmd_t c, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] i, input logic [VAL_W-1:0] p);
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    id <= i;
    phone <= p;
    do @(posedge clk); while (in_stall);
    mirror.note_request(c, k, i, p);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cmd_t             c;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] i;
    logic [VAL_W-1:0] p;
    int               burst;
    int               r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, collisions, key extremes, duplicates, partial matches
    send_request(CMD_LOOKUP, 15'd0, 32'h0, 32'h0);
    send_request(CMD_INSERT, 15'd0, 32'h0, 32'h0);
    send_request(CMD_INSERT, 15'd8, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 15'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_INSERT, 15'd0, 32'h0, 32'h0);
    send_request(CMD_LOOKUP, 15'd0, 32'h0, 32'h0);
    send_request(CMD_LOOKUP, 15'd8, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_LOOKUP, 15'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_LOOKUP, 15'd8, 32'h8000_0000, 32'h0);
    send_request(CMD_LOOKUP, 15'd8, 32'h0, 32'h7FFF_FFFF);
    send_request(CMD_LOOKUP, 15'd16, 32'h8000_0000, 32'h7FFF_FFFF);
    // same home slot near the top, forcing the probe to wrap around
    for (int n = 0; n < 2; n++) begin
      send_request(CMD_INSERT, 15'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 15'd11, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_INSERT, 15'd21, 32'h0, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 15'd27, 32'h1234_5678, 32'h8765_4321);
    end
    send_request(CMD_LOOKUP, 15'd27, 32'h1234_5678, 32'h8765_4321);
    send_request(CMD_LOOKUP, 15'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 15'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFE);

    burst = 0;
    for (int n = 0; n < 1400; n++) begin
      if (burst == 0) begin
        pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
      burst--;
      r = $urandom_range(99);
      k = KEY_W'($urandom);
      i = $urandom;
      p = $urandom;
      if ($urandom_range(99) < 12) begin
        c = CMD_INSERT;
        if (mirror.filled() > 0 && r < 25) mirror.pick_entry(k, i, p);
      end else begin
        c = CMD_LOOKUP;
        if (mirror.filled() > 0 && r < 80) begin
          mirror.pick_entry(k, i, p);
          if (r >= 60) begin
            case ($urandom_range(2))
              0: k[$urandom_range(KEY_W - 1)] ^= 1'b1;
              1: i[$urandom_range(VAL_W - 1)] ^= 1'b1;
              default: p[$urandom_range(VAL_W - 1)] ^= 1'b1;
            endcase
          end
        end
      end
      send_request(c, k, i, p);
      if (n % 350 == 349) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/htlp_pkg.sv
rtl/htlp_front.sv
rtl/htlp_queue.sv
rtl/htlp_back.sv
rtl/hash_table_linear_probe.sv
rtl/htlp_checker.sv
test/tb_hash_table_linear_probe.sv
